// ===== rtl/core/sitda_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
package sitda_pkg;

  // width of the input port and of the number that is converted
  localparam int unsigned IN_W        = 64;
  localparam int unsigned VALUE_WIDTH = 64;

  // decimal digits that cover any magnitude up to 2^(VALUE_WIDTH-1)
  localparam int unsigned NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  // result field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 5;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // job handed from the front to the back
  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } job_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONVERT,
    BK_SIZE,
    BK_EMIT
  } back_state_e;

endpackage

// ===== rtl/core/sitda_front.sv =====
// front end: takes a word, splits it into sign and unsigned magnitude
module sitda_front (
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [sitda_pkg::IN_W-1:0] value_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output sitda_pkg::job_t                 q_job_o
);

  logic [sitda_pkg::VALUE_WIDTH-1:0] raw;

  // busy while the queue has no room
  assign busy_o   = q_full_i;
  assign q_push_o = start_i & ~q_full_i;

  // sign and magnitude, the most negative value wraps to 2^(w-1) unsigned
  always_comb begin
    raw           = value_i[sitda_pkg::VALUE_WIDTH-1:0];
    q_job_o.neg   = raw[sitda_pkg::VALUE_WIDTH-1];
    q_job_o.mag   = q_job_o.neg ? (~raw + 1'b1) : raw;
  end

endmodule

// ===== rtl/core/sitda_queue.sv =====
// two entry queue of jobs between the front and the back
module sitda_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sitda_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output sitda_pkg::job_t job_o,
  output logic            empty_o
);

  sitda_pkg::job_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/sitda_back.sv =====
// back end: bit-serial binary to bcd, then one character per cycle
module sitda_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  sitda_pkg::job_t                q_job_i,
  output logic                           q_pop_o,
  output logic                           strobe_o,
  output logic [sitda_pkg::CHAR_W-1:0]   character_o,
  output logic [sitda_pkg::LEN_W-1:0]    text_length_o,
  output logic                           last_char_o
);

  sitda_pkg::back_state_e state_q, state_d;

  logic [sitda_pkg::VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [sitda_pkg::BCD_W-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [sitda_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [sitda_pkg::DIG_IDX_W-1:0]   idx_q, idx_d;
  logic [sitda_pkg::LEN_W-1:0]       total_q, total_d;
  logic [sitda_pkg::LEN_W-1:0]       num_dig;
  logic                              sign_q, sign_d;
  logic                              conv_done;
  logic                              emit_done;
  logic [3:0]                        cur_digit;

  assign conv_done = (cnt_q == sitda_pkg::CNT_W'(sitda_pkg::VALUE_WIDTH - 1));
  assign emit_done = !sign_q && (idx_q == '0);
  assign cur_digit = bcd_q[4*idx_q +: 4];

  // add-3 correction on every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // count of significant digits, at least one
  always_comb begin
    num_dig = sitda_pkg::LEN_W'(1);
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        num_dig = sitda_pkg::LEN_W'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sitda_pkg::BK_IDLE:    if (!q_empty_i) state_d = sitda_pkg::BK_CONVERT;
      sitda_pkg::BK_CONVERT: if (conv_done) state_d = sitda_pkg::BK_SIZE;
      sitda_pkg::BK_SIZE:    state_d = sitda_pkg::BK_EMIT;
      sitda_pkg::BK_EMIT:    if (emit_done) state_d = sitda_pkg::BK_IDLE;
      default:               state_d = sitda_pkg::BK_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    total_d = total_q;
    sign_d  = sign_q;
    unique case (state_q)
      sitda_pkg::BK_IDLE: begin
        mag_d  = q_job_i.mag;
        sign_d = q_job_i.neg;
        bcd_d  = '0;
        cnt_d  = '0;
      end
      sitda_pkg::BK_CONVERT: begin
        bcd_d = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_q[sitda_pkg::VALUE_WIDTH-1]};
        mag_d = {mag_q[sitda_pkg::VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      sitda_pkg::BK_SIZE: begin
        idx_d   = sitda_pkg::DIG_IDX_W'(num_dig - 1'b1);
        total_d = num_dig + {{(sitda_pkg::LEN_W-1){1'b0}}, sign_q};
      end
      sitda_pkg::BK_EMIT: begin
        if (sign_q) begin
          sign_d = 1'b0;
        end else if (idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: begin
        sign_d = sign_q;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o       = 1'b0;
    strobe_o      = 1'b0;
    character_o   = sitda_pkg::CHAR_ZERO;
    text_length_o = total_q;
    last_char_o   = 1'b0;
    unique case (state_q)
      sitda_pkg::BK_IDLE: begin
        q_pop_o = !q_empty_i;
      end
      sitda_pkg::BK_EMIT: begin
        strobe_o    = 1'b1;
        last_char_o = emit_done;
        character_o = sign_q ? sitda_pkg::CHAR_MINUS
                             : (sitda_pkg::CHAR_ZERO | {4'd0, cur_digit});
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    total_q <= total_d;
    sign_q  <= sign_d;
  end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii text converter
//
// Input channel: drive value_i and raise start_i; the word is taken at a
// rising edge where start_i is high and busy_o is low. busy_o is high only
// while the two entry job queue is full.
// Result channel: one character per cycle on character_o with strobe_o high
// for exactly that cycle. text_length_o holds the total text length (minus
// sign included) on every character, last_char_o marks the final one. The
// receiver cannot stall; every strobed cycle is a delivered character.
// Sequence: the back end takes a job from the queue, runs bit-serial
// double dabble (one shift per cycle), sizes the text, then emits the
// characters. The double dabble loop sets the rate; the front keeps
// taking words into the queue while the back end works.
// Reset: asynchronous, active low; clears the queue and returns the back
// end to idle. No state carries from one word to the next.
module signed_int_to_decimal_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [sitda_pkg::IN_W-1:0] value_i,
  output logic                              strobe_o,
  output logic [sitda_pkg::CHAR_W-1:0]      character_o,
  output logic [sitda_pkg::LEN_W-1:0]       text_length_o,
  output logic                              last_char_o
);

  sitda_pkg::job_t push_job;
  sitda_pkg::job_t pop_job;
  logic            push, pop, full, empty;

  // sign split and queue write
  sitda_front u_front (
    .start_i  (start_i),
    .busy_o   (busy_o),
    .value_i  (value_i),
    .q_full_i (full),
    .q_push_o (push),
    .q_job_o  (push_job)
  );

  // decoupling queue
  sitda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  // conversion and character output
  sitda_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_job_i       (pop_job),
    .q_pop_o       (pop),
    .strobe_o      (strobe_o),
    .character_o   (character_o),
    .text_length_o (text_length_o),
    .last_char_o   (last_char_o)
  );

endmodule

// ===== verif/signed_int_to_decimal_ascii_scoreboard.sv =====
// scoreboard for the decimal text converter: predicts every character and checks it
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_scoreboard
  import sitda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic signed [IN_W-1:0]  value_i,
  input  logic                    strobe_i,
  input  logic [CHAR_W-1:0]       character_i,
  input  logic [LEN_W-1:0]        text_length_i,
  input  logic                    last_char_i,
  output int                      error_count_o,
  output int                      pending_chars_o,
  output int                      word_count_o,
  output int                      char_count_o
);

  localparam int unsigned EFF_W = (VALUE_WIDTH > 64) ? 64 : ((VALUE_WIDTH < 1) ? 1 : VALUE_WIDTH);
  localparam logic [63:0] VAL_MASK = (EFF_W >= 64) ? '1 : ((64'd1 << EFF_W) - 64'd1);
  localparam int unsigned MAX_CHARS    = 20;
  localparam int unsigned DECIMAL_BASE = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic [LEN_W-1:0]  text_length;
    logic              last_char;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t owed_chars[$];

  int errors;
  int words;
  int chars;

  // spell one accepted word as decimal text and queue its characters
  function automatic void spell_decimal(input logic [IN_W-1:0] raw);
    logic [63:0]       u;
    logic [63:0]       mag;
    logic              neg;
    logic [CHAR_W-1:0] digits[MAX_CHARS];
    int unsigned       nd;
    int unsigned       total;
    int unsigned       pos;
    text_char_t        c;
    u   = 64'(raw) & VAL_MASK;
    neg = u[EFF_W-1];
    // magnitude through the unsigned value, so the most negative input is exact
    mag = neg ? ((~u + 64'd1) & VAL_MASK) : u;
    nd  = 0;
    do begin
      digits[nd] = CHAR_ZERO + CHAR_W'(mag % DECIMAL_BASE);
      nd++;
      mag = mag / DECIMAL_BASE;
    end while (mag != 0 && nd < MAX_CHARS);
    total = nd + (neg ? 1 : 0);
    if (total > MAX_CHARS) total = MAX_CHARS;
    pos = 0;
    if (neg) begin
      c.character   = CHAR_MINUS;
      c.text_length = LEN_W'(total);
      c.last_char   = (total == 1);
      owed_chars.push_back(c);
      pos = 1;
    end
    // digits were collected least significant first
    for (int unsigned k = 0; k < nd && pos < MAX_CHARS; k++) begin
      c.character   = digits[nd - 1 - k];
      c.text_length = LEN_W'(total);
      c.last_char   = (pos + 1 == total);
      owed_chars.push_back(c);
      pos++;
    end
  endfunction

  // watch both channels at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t oldest;
    if (!rst_ni) begin
      owed_chars.delete();
      errors = 0;
      words  = 0;
      chars  = 0;
    end else begin
      // characters leave before the new word's characters join the queue
      if (strobe_i) begin
        chars++;
        if (owed_chars.size() == 0) begin
          $error("character %0d strobed with no word pending", character_i);
          errors++;
        end else begin
          oldest = owed_chars.pop_front();
          if (character_i !== oldest.character) begin
            $error("character: expected %0d, got %0d", oldest.character, character_i);
            errors++;
          end
          if (text_length_i !== oldest.text_length) begin
            $error("text_length: expected %0d, got %0d", oldest.text_length, text_length_i);
            errors++;
          end
          if (last_char_i !== oldest.last_char) begin
            $error("last_char: expected %0b, got %0b", oldest.last_char, last_char_i);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        words++;
        spell_decimal(value_i);
      end
    end
    error_count_o   <= errors;
    pending_chars_o <= owed_chars.size();
    word_count_o    <= words;
    char_count_o    <= chars;
  end

endmodule

// ===== verif/signed_int_to_decimal_ascii_test.sv =====
// testbench top for the decimal text converter: stimulus, reset, clock and verdict
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;
  import sitda_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASE_WORDS   = 157;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] E18      = 64'd1000000000000000000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [IN_W-1:0]  value_i;
  logic                    strobe_o;
  logic [CHAR_W-1:0]       character_o;
  logic [LEN_W-1:0]        text_length_o;
  logic                    last_char_o;

  int error_count;
  int pending_chars;
  int word_count;
  int char_count;
  int idle_pct;
  int cycle_count;

  signed_int_to_decimal_ascii DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .strobe_o      (strobe_o),
    .character_o   (character_o),
    .text_length_o (text_length_o),
    .last_char_o   (last_char_o)
  );

  signed_int_to_decimal_ascii_scoreboard scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .value_i         (value_i),
    .strobe_i        (strobe_o),
    .character_i     (character_o),
    .text_length_i   (text_length_o),
    .last_char_i     (last_char_o),
    .error_count_o   (error_count),
    .pending_chars_o (pending_chars),
    .word_count_o    (word_count),
    .char_count_o    (char_count)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still owed", cycle_count,
               pending_chars);
      $display("** signed_int_to_decimal_ascii: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] pow10(input int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // random value, spread over text lengths and digit boundaries
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(63);
      2: v = pow10($urandom_range(18)) - 64'($urandom_range(1));
      3: v = 64'($urandom_range(200));
      4: v = $urandom_range(1) ? MOST_NEG + 64'($urandom_range(3)) :
                                 MOST_POS - 64'($urandom_range(3));
      default: v = {$urandom, $urandom} >> $urandom_range(63, 40);
    endcase
    if ($urandom_range(1) && v != MOST_NEG) v = -v;
    return v;
  endfunction

  // offer one word, hold it until taken, then idle at random
  task automatic send_word(input logic [63:0] v);
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      value_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
  endtask

  // hold off until every owed character has come out
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni   = 1'b0;
    start_i <= 1'b0;
    value_i <= '0;
    idle_pct = 7;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, zero, sign handling and digit count boundaries
    send_word(64'd0);
    send_word(64'd1);
    send_word(-64'd1);
    send_word(64'd9);
    send_word(64'd10);
    send_word(-64'd10);
    send_word(64'd99);
    send_word(-64'd100);
    send_word(MOST_POS);
    send_word(MOST_NEG);
    send_word(MOST_NEG + 64'd1);
    send_word(E18);
    send_word(E18 - 64'd1);
    send_word(-E18);
    send_word(-(E18 - 64'd1));
    send_word(64'h5555_5555_5555_5555);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'hFFFF_FFFF_0000_0000);
    send_word(64'h0000_0000_FFFF_FFFF);
    send_word(-64'd7);
    wait_drained();

    // light sender idling
    for (int i = 0; i < PHASE_WORDS; i++) begin
      send_word(pick_value());
      if ($urandom_range(39) == 0) wait_drained();
    end
    wait_drained();

    // heavy sender idling
    idle_pct = 75;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      send_word(pick_value());
      if ($urandom_range(39) == 0) wait_drained();
    end
    wait_drained();

    // back to back
    idle_pct = 0;
    for (int i = 0; i < PHASE_WORDS; i++) send_word(pick_value());
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("converted %0d words into %0d characters, zero and both extremes included,",
             word_count, char_count);
    $display("under light, heavy and no sender idling with full drains between bursts");
    if (pending_chars != 0) begin
      $error("%0d characters never came out", pending_chars);
    end
    if (error_count == 0 && pending_chars == 0) begin
      $display("** signed_int_to_decimal_ascii: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

endmodule
